// ===== design/sawam_pkg.sv =====
`default_nettype none
package sawam_pkg;

  // phase accumulator fraction bits
  localparam int PHASE_BITS = 24;
  // fraction bits of the FM scale factor
  localparam int FM_FRAC    = 23;

  localparam int LEVEL_W    = 16;
  localparam int DEPTH_W    = 16;
  localparam int AMPL_W     = 16;
  // selected amplitude, 16 fraction bits, up to 2 * 65535
  localparam int AMP_W      = AMPL_W + 1;
  // raw sawtooth, signed, range -2^PHASE_BITS .. 2^PHASE_BITS
  localparam int RAW_W      = PHASE_BITS + 2;
  // second multiplier operand, signed, holds 2^FM_FRAC + fm * depth
  localparam int MB_W       = LEVEL_W + DEPTH_W + 1;
  localparam int PROD_W     = RAW_W + MB_W;
  // fm * depth product
  localparam int K_W        = LEVEL_W + DEPTH_W + 1;
  // divisor 2^FM_FRAC + |k| stays below 2^32
  localparam int DVS_W      = LEVEL_W + DEPTH_W;
  localparam int NUM_W      = PHASE_BITS + FM_FRAC;
  localparam int CNT_W      = $clog2(PHASE_BITS);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = PHASE_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_INC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEF_AMP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FM_DEPTH  = 2'd2;

  localparam logic [AMPL_W-1:0] DEF_AMP_RESET = 16'h8000;

endpackage
`default_nettype wire

// ===== design/sawam_ifs.sv =====
`default_nettype none

// sample tick request with modulation inputs
interface sawam_tick_if import sawam_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      amp_valid;
  logic        [LEVEL_W-1:0] amp_level;
  logic                      am_valid;
  logic signed [LEVEL_W-1:0] am_level;
  logic                      fm_valid;
  logic signed [LEVEL_W-1:0] fm_level;

  modport source (output valid, amp_valid, amp_level, am_valid, am_level,
                  fm_valid, fm_level, input ready);
  modport sink   (input valid, amp_valid, amp_level, am_valid, am_level,
                  fm_valid, fm_level, output ready);
endinterface

// output sample request
interface sawam_wave_if import sawam_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [LEVEL_W-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

// register write request
interface sawam_cfg_if import sawam_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/sawtooth_oscillator_am_fm_top.sv =====
`default_nettype none
// Sawtooth oscillator with AM and FM on a 24-bit phase accumulator. Every tick
// request yields exactly one signed Q1.15 sample taken from the phase before it
// advances. One multiplier is shared in turn for the amplitude product, the FM
// factor fm_level * fm_depth and, for positive FM, the scaled step; negative FM
// divides the step with a restoring divider that settles one quotient bit per
// cycle. A tick passes MULA, MULK and CHK, then goes to DONE directly without
// FM or with a zero FM factor, via SCALE with a positive factor and via the DIV
// loop with a negative one. The finished sample sits in an output register; a
// stalled output holds the block in its final step. The write port is always
// ready. The user must write base_increment (index 0), default_amplitude (1)
// and fm_depth (2) only while idle; the block itself does not enforce this.
module sawtooth_oscillator_am_fm_top import sawam_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  sawam_tick_if.sink    tick,
  sawam_wave_if.source  wave,
  sawam_cfg_if.sink     cfg
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MULA  = 3'd1;
  localparam logic [2:0] ST_MULK  = 3'd2;
  localparam logic [2:0] ST_CHK   = 3'd3;
  localparam logic [2:0] ST_SCALE = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam logic [PHASE_BITS-1:0] PHASE_MASK = {PHASE_BITS{1'b1}};
  localparam logic [PHASE_BITS-1:0] PHASE_HALF = PHASE_BITS'(1) << (PHASE_BITS - 1);
  localparam logic signed [RAW_W-1:0] RAW_WRAP = RAW_W'(1) << (PHASE_BITS + 1);
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << PHASE_BITS;
  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_LO = -PROD_W'(32768);
  localparam logic signed [K_W-1:0] FM_ONE = K_W'(1) << FM_FRAC;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PHASE_BITS - 1);

  // configuration registers
  logic [PHASE_BITS-1:0] base_inc;
  logic [AMPL_W-1:0]     def_amp;
  logic [DEPTH_W-1:0]    fm_depth;

  // sequencer and datapath registers
  logic [2:0]                state;
  logic [PHASE_BITS-1:0]     phase_acc;
  logic [AMP_W-1:0]          amp_sel;
  logic signed [LEVEL_W-1:0] fm_sel;
  logic signed [PROD_W-1:0]  prod;
  logic signed [LEVEL_W-1:0] sample;
  logic [PHASE_BITS-1:0]     step;
  logic [DVS_W-1:0]          rem;
  logic [DVS_W-1:0]          dvs;
  logic [PHASE_BITS-1:0]     nbits;
  logic [CNT_W-1:0]          cnt;
  logic                      out_valid;
  logic signed [LEVEL_W-1:0] out_sample;

  // combinational helpers
  logic signed [RAW_W-1:0]  raw;
  logic signed [RAW_W-1:0]  mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] rnd;
  logic signed [LEVEL_W-1:0] sample_next;
  logic signed [K_W-1:0]    k;
  logic [K_W-1:0]           k_neg;
  logic [PROD_W-FM_FRAC-1:0] scaled;
  logic [NUM_W-1:0]         num;
  logic [DVS_W:0]           shifted;
  logic                     div_ge;
  logic                     tick_acc;

  assign tick.ready = (state == ST_IDLE);
  assign tick_acc   = tick.valid && tick.ready;
  assign cfg.ready  = 1'b1;
  assign wave.valid = out_valid;
  assign wave.sample_out = out_sample;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_inc <= '0;
      def_amp  <= DEF_AMP_RESET;
      fm_depth <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_BASE_INC: base_inc <= cfg.data;
        REG_DEF_AMP:  def_amp  <= cfg.data[AMPL_W-1:0];
        REG_FM_DEPTH: fm_depth <= cfg.data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // raw sawtooth from the current phase
  always_comb begin
    raw = $signed({1'b0, phase_acc, 1'b0});
    if (phase_acc > PHASE_HALF) begin
      raw = raw - RAW_WRAP;
    end
  end

  // shared multiplier operand select
  always_comb begin
    k = prod[K_W-1:0];
    unique case (state)
      ST_MULA: begin
        mul_a = raw;
        mul_b = $signed({{(MB_W-AMP_W){1'b0}}, amp_sel});
      end
      ST_MULK: begin
        mul_a = {{(RAW_W-LEVEL_W){fm_sel[LEVEL_W-1]}}, fm_sel};
        mul_b = $signed({{(MB_W-DEPTH_W){1'b0}}, fm_depth});
      end
      ST_CHK: begin
        mul_a = $signed({{(RAW_W-PHASE_BITS){1'b0}}, base_inc});
        mul_b = MB_W'(FM_ONE + k);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sample rounding and saturation
  always_comb begin
    rnd = (prod + RND_HALF) >>> (PHASE_BITS + 1);
    if (rnd > SAT_HI) begin
      sample_next = SAT_HI[LEVEL_W-1:0];
    end else if (rnd < SAT_LO) begin
      sample_next = SAT_LO[LEVEL_W-1:0];
    end else begin
      sample_next = rnd[LEVEL_W-1:0];
    end
  end

  // step helpers: scaled product, divider setup and trial subtract
  assign scaled  = prod[PROD_W-1:FM_FRAC];
  assign k_neg   = -k;
  assign num     = {base_inc, {FM_FRAC{1'b0}}};
  assign shifted = {rem, nbits[PHASE_BITS-1]};
  assign div_ge  = (shifted >= {1'b0, dvs});

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase_acc <= '0;
      out_valid <= 1'b0;
    end else begin
      // the final step refills the output register itself
      if (wave.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (tick_acc) begin
            state <= ST_MULA;
          end
        end
        ST_MULA:  state <= ST_MULK;
        ST_MULK:  state <= ST_CHK;
        ST_CHK: begin
          if (k > 0) begin
            state <= ST_SCALE;
          end else if (k < 0) begin
            state <= ST_DIV;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_SCALE: state <= ST_DONE;
        ST_DIV: begin
          if (cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || wave.ready) begin
            out_valid <= 1'b1;
            phase_acc <= phase_acc + step;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (tick_acc) begin
          if (tick.am_valid) begin
            amp_sel <= {1'b0, ~tick.am_level[LEVEL_W-1], tick.am_level[LEVEL_W-2:0]};
          end else if (tick.amp_valid) begin
            amp_sel <= {tick.amp_level, 1'b0};
          end else begin
            amp_sel <= {def_amp, 1'b0};
          end
          fm_sel <= tick.fm_valid ? tick.fm_level : '0;
        end
      end
      ST_MULA: prod <= mul_a * mul_b;
      ST_MULK: begin
        sample <= sample_next;
        prod   <= mul_a * mul_b;
      end
      ST_CHK: begin
        prod  <= mul_a * mul_b;
        step  <= base_inc;
        rem   <= DVS_W'(num >> PHASE_BITS);
        nbits <= num[PHASE_BITS-1:0];
        dvs   <= DVS_W'(FM_ONE + $signed(k_neg));
        cnt   <= CNT_LAST;
      end
      ST_SCALE: begin
        step <= (scaled > (PROD_W-FM_FRAC)'(PHASE_MASK)) ? PHASE_MASK
                                                          : scaled[PHASE_BITS-1:0];
      end
      ST_DIV: begin
        rem   <= div_ge ? DVS_W'(shifted - {1'b0, dvs}) : shifted[DVS_W-1:0];
        nbits <= {nbits[PHASE_BITS-2:0], 1'b0};
        step  <= {step[PHASE_BITS-2:0], div_ge};
        cnt   <= cnt - 1'b1;
      end
      ST_DONE: begin
        if (!out_valid || wave.ready) begin
          out_sample <= sample;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== tb/sawtooth_oscillator_am_fm_top_tb.sv =====
`default_nettype none

module sawtooth_oscillator_am_fm_top_tb;
  import sawam_pkg::*;

  // one sample tick as offered on the tick channel
  typedef struct packed {
    logic               amp_valid;
    logic [LEVEL_W-1:0] amp_level;
    logic               am_valid;
    logic [LEVEL_W-1:0] am_level;
    logic               fm_valid;
    logic [LEVEL_W-1:0] fm_level;
  } tick_t;

  // predicts each sample from its own copy of phase and registers,
  // holds the samples still owed by the block
  class sawtooth_scoreboard;
    logic [PHASE_BITS-1:0] phase;
    logic [PHASE_BITS-1:0] base_inc;
    logic [AMPL_W-1:0]     def_amp;
    logic [DEPTH_W-1:0]    depth;
    logic [LEVEL_W-1:0]    samples_due[$];
    int                    errors;

    function new();
      phase    = '0;
      base_inc = '0;
      def_amp  = DEF_AMP_RESET;
      depth    = '0;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BASE_INC: base_inc = data[PHASE_BITS-1:0];
        REG_DEF_AMP:  def_amp  = data[AMPL_W-1:0];
        REG_FM_DEPTH: depth    = data[DEPTH_W-1:0];
        default: ;
      endcase
    endfunction

    // sawtooth of the current phase times the selected amplitude
    function logic [LEVEL_W-1:0] sample_for(tick_t t);
      longint raw;
      longint amp;
      longint prod;
      longint s;
      raw = longint'(phase) * 2;
      if (longint'(phase) > (longint'(1) << (PHASE_BITS - 1)))
        raw = raw - (longint'(1) << (PHASE_BITS + 1));
      if (t.am_valid)
        amp = longint'($signed(t.am_level)) + 32768;
      else if (t.amp_valid)
        amp = longint'(t.amp_level) * 2;
      else
        amp = longint'(def_amp) * 2;
      // round half up, floor via arithmetic shift
      prod = raw * amp + (longint'(1) << PHASE_BITS);
      s = prod >>> (PHASE_BITS + 1);
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      return s[LEVEL_W-1:0];
    endfunction

    // phase step, scaled up or divided down by the FM factor
    function logic [PHASE_BITS-1:0] step_for(tick_t t);
      longint k;
      longint st;
      longint fm_one;
      longint step_max;
      fm_one   = longint'(1) << FM_FRAC;
      step_max = (longint'(1) << PHASE_BITS) - 1;
      st = longint'(base_inc);
      if (t.fm_valid) begin
        k = longint'($signed(t.fm_level)) * longint'(depth);
        if (k > 0)
          st = (longint'(base_inc) * (fm_one + k)) >>> FM_FRAC;
        else if (k < 0)
          st = (longint'(base_inc) <<< FM_FRAC) / (fm_one - k);
      end
      if (st > step_max) st = step_max;
      return st[PHASE_BITS-1:0];
    endfunction

    function void note_tick(tick_t t);
      samples_due.push_back(sample_for(t));
      phase = phase + step_for(t);
    endfunction

    function void check_sample(logic [LEVEL_W-1:0] got);
      logic [LEVEL_W-1:0] want;
      if (samples_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("sample %0d arrived with no tick outstanding", $signed(got));
      end else begin
        want = samples_due.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("sample_out mismatch: expected %0d, got %0d",
                     $signed(want), $signed(got));
        end
      end
    endfunction

    function int pending();
      return samples_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  sawam_tick_if tick_ch ();
  sawam_wave_if wave_ch ();
  sawam_cfg_if  cfg_ch ();

  sawtooth_oscillator_am_fm_top dut (
    .clk  (clk),
    .rst  (rst),
    .tick (tick_ch),
    .wave (wave_ch),
    .cfg  (cfg_ch)
  );

  sawtooth_scoreboard sb;

  // idling controls for the sender (tx_steady) and the receiver (rx_steady, rx_hold)
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int rx_hold   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #5000000;
    $display("timeout waiting on handshakes");
    $display("RESULT: ERROR");
    $finish;
  end

  // sample receiver with random stalls and the occasional long hold-off
  initial begin : wave_sink
    int gap;
    wave_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    wave_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      gap = 0;
      if (wave_ch.valid && wave_ch.ready) begin
        sb.check_sample(wave_ch.sample_out);
        gap = rx_steady ? 0 : $urandom_range(0, 17);
      end
      if (rx_hold > 0) begin
        gap = rx_hold;
        rx_hold = 0;
      end
      if (gap > 0) begin
        wave_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        wave_ch.ready <= 1'b1;
      end
    end
  end

  function automatic tick_t tick_of(bit amp_v, logic [15:0] amp_l, bit am_v,
                                    logic [15:0] am_l, bit fm_v, logic [15:0] fm_l);
    tick_t t;
    t.amp_valid = amp_v;
    t.amp_level = amp_l;
    t.am_valid  = am_v;
    t.am_level  = am_l;
    t.fm_valid  = fm_v;
    t.fm_level  = fm_l;
    return t;
  endfunction

  // mostly uniform, sometimes a corner value
  function automatic logic [LEVEL_W-1:0] pick_level();
    logic [LEVEL_W-1:0] corners[6];
    corners = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'h8001, 16'hFFFF};
    if ($urandom_range(0, 5) == 0)
      return corners[$urandom_range(0, 5)];
    return LEVEL_W'($urandom_range(0, 65535));
  endfunction

  function automatic tick_t random_tick();
    return tick_of(1'($urandom_range(0, 1)), pick_level(), 1'($urandom_range(0, 1)),
                   pick_level(), 1'($urandom_range(0, 1)), pick_level());
  endfunction

  task automatic send_tick(input tick_t t);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid     <= 1'b1;
    tick_ch.amp_valid <= t.amp_valid;
    tick_ch.amp_level <= t.amp_level;
    tick_ch.am_valid  <= t.am_valid;
    tick_ch.am_level  <= t.am_level;
    tick_ch.fm_valid  <= t.fm_valid;
    tick_ch.fm_level  <= t.fm_level;
    do @(posedge clk); while (!tick_ch.ready);
    sb.note_tick(t);
  endtask

  // stop offering ticks and wait for every owed sample
  task automatic drain();
    tick_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
  endtask

  // block must be idle here
  task automatic write_regs(input logic [PHASE_BITS-1:0] base, input logic [AMPL_W-1:0] amp,
                            input logic [DEPTH_W-1:0] fm_depth);
    cfg_put(REG_BASE_INC, CFG_DATA_W'(base));
    cfg_put(REG_DEF_AMP, CFG_DATA_W'(amp));
    cfg_put(REG_FM_DEPTH, CFG_DATA_W'(fm_depth));
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [PHASE_BITS-1:0] base;
    logic [AMPL_W-1:0]     amp;
    logic [DEPTH_W-1:0]    fm_depth;
    sb = new();
    tick_ch.valid     <= 1'b0;
    tick_ch.amp_valid <= 1'b0;
    tick_ch.amp_level <= '0;
    tick_ch.am_valid  <= 1'b0;
    tick_ch.am_level  <= '0;
    tick_ch.fm_valid  <= 1'b0;
    tick_ch.fm_level  <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= '0;
    cfg_ch.data       <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset register values: zero step, phase stays at zero
    send_tick(tick_of(1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0, 16'h0000));
    send_tick(tick_of(1'b0, 16'h0000, 1'b0, 16'h0000, 1'b1, 16'h7FFF));
    send_tick(tick_of(1'b1, 16'hFFFF, 1'b0, 16'h0000, 1'b0, 16'h0000));
    drain();

    // quarter-cycle step walks 0, 1/4, exactly 1/2, 3/4; default amplitude above one
    write_regs(24'h400000, 16'hFFFF, 16'h0100);
    send_tick(tick_of(1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0, 16'h0000));
    send_tick(tick_of(1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0, 16'h0000));
    send_tick(tick_of(1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0, 16'h0000));
    send_tick(tick_of(1'b1, 16'h0000, 1'b0, 16'h0000, 1'b0, 16'h0000));
    send_tick(tick_of(1'b1, 16'h8000, 1'b0, 16'h0000, 1'b0, 16'h0000));
    send_tick(tick_of(1'b1, 16'hFFFF, 1'b0, 16'h0000, 1'b0, 16'h0000));
    send_tick(tick_of(1'b0, 16'h0000, 1'b1, 16'h8000, 1'b0, 16'h0000));
    send_tick(tick_of(1'b0, 16'h0000, 1'b1, 16'h7FFF, 1'b0, 16'h0000));
    // AM wins over amp
    send_tick(tick_of(1'b1, 16'hFFFF, 1'b1, 16'h0000, 1'b0, 16'h0000));
    // FM level ignored while disconnected
    send_tick(tick_of(1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0, 16'h7FFF));
    send_tick(tick_of(1'b0, 16'h0000, 1'b0, 16'h0000, 1'b1, 16'h7FFF));
    send_tick(tick_of(1'b0, 16'h0000, 1'b0, 16'h0000, 1'b1, 16'h8000));
    send_tick(tick_of(1'b0, 16'h0000, 1'b0, 16'h0000, 1'b1, 16'h0000));
    drain();

    // full step with deepest FM: step saturation and the largest divisor
    write_regs(24'hFFFFFF, 16'h0000, 16'hFFFF);
    send_tick(tick_of(1'b0, 16'h0000, 1'b0, 16'h0000, 1'b1, 16'h7FFF));
    send_tick(tick_of(1'b0, 16'h0000, 1'b0, 16'h0000, 1'b1, 16'h8000));
    send_tick(tick_of(1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0, 16'h0000));
    send_tick(tick_of(1'b0, 16'h0000, 1'b1, 16'hFFFF, 1'b0, 16'h0000));
    send_tick(tick_of(1'b1, 16'h0001, 1'b0, 16'h0000, 1'b1, 16'h0001));
    drain();

    // random phases, each under its own register setting
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin base = 24'hFFFFFF; amp = 16'h0000; fm_depth = 16'hFFFF; end
        1: begin base = 24'h000000; amp = 16'hFFFF; fm_depth = 16'h0000; end
        2: begin base = PHASE_BITS'($urandom_range(1, 65536)); amp = 16'h8000;
                 fm_depth = DEPTH_W'($urandom_range(0, 1023)); end
        default: begin
          base = ($urandom_range(0, 1) == 0) ? PHASE_BITS'($urandom_range(0, 24'hFFFFFF))
                                             : PHASE_BITS'($urandom_range(0, 24'h00FFFF));
          amp = AMPL_W'($urandom_range(0, 65535));
          fm_depth = ($urandom_range(0, 1) == 0) ? DEPTH_W'($urandom_range(0, 65535))
                                                 : DEPTH_W'($urandom_range(0, 511));
        end
      endcase
      write_regs(base, amp, fm_depth);
      for (int i = 0; i < 140; i++) begin
        if (i % 32 == 0) begin
          tx_steady = ($urandom_range(0, 3) == 0);
          rx_steady = ($urandom_range(0, 3) == 0);
        end
        // long receiver hold-off while ticks keep coming back to back
        if (p == 2 && i == 0) begin
          tx_steady = 1'b1;
          rx_hold = 300;
        end
        send_tick(random_tick());
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/sawam_pkg.sv
design/sawam_ifs.sv
design/sawtooth_oscillator_am_fm_top.sv
tb/sawtooth_oscillator_am_fm_top_tb.sv
